// ===== sv/accel_bias_calibration_and_tilt_macros.svh =====
// Assertion macros for the accelerometer bias calibration block.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef ACCEL_BIAS_CALIBRATION_AND_TILT_MACROS_SVH
`define ACCEL_BIAS_CALIBRATION_AND_TILT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ABCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ABCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/abct_pkg.sv =====
// Shared types and constants for the accelerometer bias calibration block.
// Used by abct_div and accel_bias_calibration_and_tilt; no dependencies.
package abct_pkg;

  localparam int MG_W     = 12;  // one axis reading in mg
  localparam int HELD_W   = 14;  // bias-corrected reading
  localparam int OFFZ_W   = 13;  // Z bias carries the 1 g offset
  localparam int PITCH_W  = 13;
  localparam int PROD_W   = 24;  // |held_x| * 573
  localparam int DIV_W    = 28;  // dividend / calibration sum width
  localparam int DVS_W    = 16;  // divisor width
  localparam int CNT_W    = 16;  // calibration item counters

  localparam int PITCH_MUL  = 573;
  localparam int PITCH_DIV  = 1000;
  localparam int Z_ONE_G_MG = 1000;
  localparam int CAL_COUNT_RESET = 16;

  // Divide by 1000 as (p * RECIP_1000) >> RECIP_SH, exact for p below 2^22.
  localparam int RECIP_W  = 20;
  localparam int RECIP_SH = 29;
  localparam int SCALE_W  = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 20'd536871;  // ceil(2^29 / 1000)

  typedef enum logic [2:0] {
    ST_SAMPLE_DONE = 3'd0,
    ST_READ_FAIL   = 3'd1,
    ST_CALIBRATING = 3'd2,
    ST_CAL_DONE    = 3'd3,
    ST_CAL_FAIL    = 3'd4
  } status_t;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
    logic [DVS_W-1:0]        divisor;   // never zero when started
  } div_req_t;

  typedef struct packed {
    logic                    done;      // one-cycle pulse
    logic signed [DIV_W-1:0] quotient;  // truncated toward zero
  } div_rsp_t;

  // Left-justified 16-bit word, arithmetic shift right by 4.
  function automatic logic signed [MG_W-1:0] word_to_mg(input logic [15:0] raw);
    word_to_mg = $signed(raw[15:4]);
  endfunction

endpackage

// ===== sv/abct_div.sv =====
// Shared iterative divider: signed dividend by unsigned divisor, one bit a cycle.
// Depends on abct_pkg for widths and the request/response structs.
module abct_div
  import abct_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(DIV_W);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] count;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  divisor;
  logic [DIV_W-1:0]  quo;
  logic              neg;

  logic [DVS_W:0] shifted;
  logic [DVS_W:0] trial;
  logic           fits;

  // restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem, quo[DIV_W-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= STEP_W'(DIV_W - 1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg     <= req.dividend[DIV_W-1];
      quo     <= req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? DIV_W'(-quo) : quo;

endmodule

// ===== sv/accel_bias_calibration_and_tilt.sv =====
// Accelerometer bias calibration and small-angle pitch, top level.
// Depends on abct_pkg, abct_div and accel_bias_calibration_and_tilt_macros.svh.
//
//   channel   direction  handshake              payload
//   s_axis    in         tvalid/tready          tdata: x, y, z raw; tuser: req_type, read_ok
//   m_axis    out        tvalid/tready          tdata: acc x/y/z, pitch; tuser: status
//   cfg       in         cfg_wen (no wait)      cfg_wdata: cal_count
//
// One request at a time: s_axis_tready is high only while idle.
// A sample passes the update, multiply, scale and sign states before its
// result is valid; a calibration request also passes the end-of-run check.
// The next request goes in once the result is taken. Closing a run with good
// readings adds three bias divisions on the shared divider, one quotient bit
// per cycle. Pitch scaling by 1000 is a reciprocal multiply. Reset (rst,
// synchronous) clears bias, held values, sums, counters, and sets cal_count to
// 16. A stalled result holds in place until m_axis_tready.
`include "accel_bias_calibration_and_tilt_macros.svh"

module accel_bias_calibration_and_tilt
  import abct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] accel_x_raw, [31:16] accel_y_raw,
                                      // [47:32] accel_z_raw
  input  logic [1:0]  s_axis_tuser,   // [0] req_type, [1] read_ok
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [13:0] acc_x, [27:14] acc_y, [41:28] acc_z,
                                      // [54:42] pitch_ddeg, [55] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  // cal_count register
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,   // apply the reading to sums or held values
    S_CHECK,    // end-of-run test, launch bias divisions
    S_WAIT_X,
    S_WAIT_Y,
    S_WAIT_Z,
    S_MUL,      // |held_x| * 573
    S_SCALE,    // times the reciprocal of 1000
    S_SIGN,     // restore the sign of the pitch
    S_OUT
  } state_t;

  state_t state;

  logic [CNT_W-1:0] cal_count;

  // latched request
  logic                   in_cal;
  logic                   in_ok;
  logic signed [MG_W-1:0] in_x;
  logic signed [MG_W-1:0] in_y;
  logic signed [MG_W-1:0] in_z;

  // calibration run
  logic signed [DIV_W-1:0] sum_x;
  logic signed [DIV_W-1:0] sum_y;
  logic signed [DIV_W-1:0] sum_z;
  logic [CNT_W-1:0]        cal_items_seen;
  logic [CNT_W-1:0]        cal_items_good;

  // bias and held reading
  logic signed [MG_W-1:0]    offset_x;
  logic signed [MG_W-1:0]    offset_y;
  logic signed [OFFZ_W-1:0]  offset_z;
  logic signed [HELD_W-1:0]  held_x;
  logic signed [HELD_W-1:0]  held_y;
  logic signed [HELD_W-1:0]  held_z;
  logic signed [PITCH_W-1:0] pitch;
  status_t                   status;

  // pitch path: magnitude scaled, sign applied last (truncates toward zero)
  logic [HELD_W-1:0]  abs_x;
  logic [PROD_W-1:0]  prod;
  logic               pitch_neg;
  logic [SCALE_W-1:0] scaled;
  logic [PITCH_W-1:0] pitch_mag;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [CNT_W-1:0] limit;

  // a zero count behaves as one
  assign limit = (cal_count == '0) ? CNT_W'(1) : cal_count;

  assign abs_x     = held_x[HELD_W-1] ? $unsigned(-held_x) : $unsigned(held_x);
  assign pitch_mag = scaled[RECIP_SH +: PITCH_W];

  abct_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cal_count      <= CNT_W'(CAL_COUNT_RESET);
      sum_x          <= '0;
      sum_y          <= '0;
      sum_z          <= '0;
      cal_items_seen <= '0;
      cal_items_good <= '0;
      offset_x       <= '0;
      offset_y       <= '0;
      offset_z       <= '0;
      held_x         <= '0;
      held_y         <= '0;
      held_z         <= '0;
      div_req        <= '0;
      status         <= ST_SAMPLE_DONE;
    end else begin
      div_req.start <= 1'b0;

      if (cfg_wen) begin
        cal_count <= cfg_wdata;
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            in_cal <= s_axis_tuser[0];
            in_ok  <= s_axis_tuser[1];
            in_x   <= word_to_mg(s_axis_tdata[15:0]);
            in_y   <= word_to_mg(s_axis_tdata[31:16]);
            in_z   <= word_to_mg(s_axis_tdata[47:32]);
            state  <= S_UPDATE;
          end
        end

        S_UPDATE: begin
          if (in_cal) begin
            if (in_ok) begin
              sum_x          <= sum_x + DIV_W'(in_x);
              sum_y          <= sum_y + DIV_W'(in_y);
              sum_z          <= sum_z + DIV_W'(in_z);
              cal_items_good <= cal_items_good + 1'b1;
            end
            cal_items_seen <= cal_items_seen + 1'b1;
            state          <= S_CHECK;
          end else if (in_ok) begin
            held_x <= HELD_W'(in_x) - HELD_W'(offset_x);
            held_y <= HELD_W'(in_y) - HELD_W'(offset_y);
            held_z <= HELD_W'(in_z) - HELD_W'(offset_z);
            status <= ST_SAMPLE_DONE;
            state  <= S_MUL;
          end else begin
            status <= ST_READ_FAIL;
            state  <= S_MUL;
          end
        end

        S_CHECK: begin
          if (cal_items_seen >= limit) begin
            if (cal_items_good == '0) begin
              // no good reading in the run: bias stays
              status         <= ST_CAL_FAIL;
              sum_x          <= '0;
              sum_y          <= '0;
              sum_z          <= '0;
              cal_items_seen <= '0;
              cal_items_good <= '0;
              state          <= S_MUL;
            end else begin
              div_req.start    <= 1'b1;
              div_req.dividend <= sum_x;
              div_req.divisor  <= cal_items_good;
              state            <= S_WAIT_X;
            end
          end else begin
            status <= ST_CALIBRATING;
            state  <= S_MUL;
          end
        end

        S_WAIT_X: begin
          if (div_rsp.done) begin
            offset_x         <= div_rsp.quotient[MG_W-1:0];
            div_req.start    <= 1'b1;
            div_req.dividend <= sum_y;
            div_req.divisor  <= cal_items_good;
            state            <= S_WAIT_Y;
          end
        end

        S_WAIT_Y: begin
          if (div_rsp.done) begin
            offset_y         <= div_rsp.quotient[MG_W-1:0];
            div_req.start    <= 1'b1;
            div_req.dividend <= sum_z;
            div_req.divisor  <= cal_items_good;
            state            <= S_WAIT_Z;
          end
        end

        S_WAIT_Z: begin
          if (div_rsp.done) begin
            // Z bias removes the 1 g the sensor sees at rest
            offset_z       <= OFFZ_W'($signed(div_rsp.quotient[MG_W-1:0]))
                              - OFFZ_W'(Z_ONE_G_MG);
            status         <= ST_CAL_DONE;
            sum_x          <= '0;
            sum_y          <= '0;
            sum_z          <= '0;
            cal_items_seen <= '0;
            cal_items_good <= '0;
            state          <= S_MUL;
          end
        end

        S_MUL: begin
          prod      <= PROD_W'(abs_x) * PROD_W'(PITCH_MUL);
          pitch_neg <= held_x[HELD_W-1];
          state     <= S_SCALE;
        end

        S_SCALE: begin
          scaled <= SCALE_W'(prod) * SCALE_W'(RECIP_1000);
          state  <= S_SIGN;
        end

        S_SIGN: begin
          pitch <= pitch_neg ? -$signed(pitch_mag) : $signed(pitch_mag);
          state <= S_OUT;
        end

        S_OUT: begin
          if (m_axis_tready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {1'b0, pitch, held_z, held_y, held_x};
  assign m_axis_tuser  = status;

  // divider results only arrive while the sequencer waits for one
  `ABCT_ASSERT_NOW(a_div_done_in_wait, div_rsp.done,
    state == S_WAIT_X || state == S_WAIT_Y || state == S_WAIT_Z,
    "divider finished outside a wait state")
  // input and output sides are never open at once
  `ABCT_ASSERT_NOW(a_one_request, s_axis_tready, !m_axis_tvalid,
    "input accepted while a result is pending")
  // an accepted request goes straight to the update step
  `ABCT_ASSERT_NEXT(a_accept_update, s_axis_tvalid && s_axis_tready, state == S_UPDATE,
    "accepted request not processed")
  // good items are a subset of the items in the run
  `ABCT_ASSERT_NOW(a_good_le_seen, 1'b1, cal_items_good <= cal_items_seen,
    "calibration good count exceeds item count")

endmodule
